// File: rtl/cfba_pkg.sv
// ----------------------------------------------------------------------------
// cfba_pkg: shared types and constants of the chained free block allocator
// Field widths, list markers, result select codes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cfba_pkg;

    localparam int unsigned BLK_W             = 10;
    localparam int unsigned ENTRY_W           = 11;
    localparam int unsigned CMP_W             = 17;
    localparam int unsigned NODE_BLOCK_MAX    = 1024;
    localparam int unsigned CACHE_ENTRIES_DEF = 32;
    localparam int unsigned DISK_BLOCKS_DEF   = 1024;

    localparam logic [ENTRY_W-1:0] END_MARK = 11'h7FF;

    localparam logic KIND_ALLOC     = 1'b0;
    localparam logic KIND_FREE      = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NOSPACE = 1'b1;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_NOSPACE,
        RES_CACHE,
        RES_HEAD
    } cfba_res_sel_t;

    typedef struct packed {
        logic          latch_req;
        logic          push;
        logic          pop;
        logic          spill_start;
        logic          spill_step;
        logic          refill_start;
        logic          refill_step;
        logic          load_out;
        cfba_res_sel_t res_sel;
    } cfba_cmd_t;

    typedef struct packed {
        logic blk_in_range;
        logic count_zero;
        logic count_full;
        logic head_end;
        logic spill_last;
        logic refill_last;
        logic out_free;
    } cfba_stat_t;

endpackage

`default_nettype wire

// File: rtl/cfba_req_if.sv
// ----------------------------------------------------------------------------
// cfba_req_if: request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfba_req_if import cfba_pkg::*;;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [BLK_W-1:0] block_number;

    modport source (output valid, output kind, output block_number, input ready);
    modport sink   (input valid, input kind, input block_number, output ready);
endinterface

`default_nettype wire

// File: rtl/cfba_res_if.sv
// ----------------------------------------------------------------------------
// cfba_res_if: result channel
// Valid/ready channel carrying the status and granted block of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfba_res_if import cfba_pkg::*;;
    logic             valid;
    logic             ready;
    logic             status;
    logic [BLK_W-1:0] allocated_block;

    modport source (output valid, output status, output allocated_block, input ready);
    modport sink   (input valid, input status, input allocated_block, output ready);
endinterface

`default_nettype wire

// File: rtl/cfba_datapath.sv
// ----------------------------------------------------------------------------
// cfba_datapath: cache, link memory and result register
// Holds the free count, the chain head, the cache of free block numbers, the
// link node memory and the output register; acts on controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_datapath
    import cfba_pkg::*;
#(
    parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int unsigned DISK_BLOCKS   = DISK_BLOCKS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [BLK_W-1:0] blk_in,
    input  wire cfba_cmd_t        cmd,
    output cfba_stat_t            stat,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output logic                  res_status,
    output logic [BLK_W-1:0]      res_block
);

    localparam int unsigned CIDX_W      = $clog2(CACHE_ENTRIES);
    localparam int unsigned STEP_W      = $clog2(CACHE_ENTRIES + 1);
    localparam int unsigned NODE_BLOCKS = (DISK_BLOCKS < NODE_BLOCK_MAX) ?
                                          DISK_BLOCKS : NODE_BLOCK_MAX;
    localparam int unsigned NODE_W      = $clog2(NODE_BLOCKS);
    localparam int unsigned LINK_AW     = NODE_W + CIDX_W;
    localparam int unsigned LINK_DEPTH  = NODE_BLOCKS * (2 ** CIDX_W);

    localparam logic [CIDX_W-1:0] LAST_SLOT = CIDX_W'(CACHE_ENTRIES - 1);

    logic [ENTRY_W-1:0] cache_mem [CACHE_ENTRIES];
    logic [ENTRY_W-1:0] link_mem  [LINK_DEPTH];

    logic [CIDX_W-1:0]  count_reg, count_next;
    logic [ENTRY_W-1:0] head_reg,  head_next;
    logic [STEP_W-1:0]  step_reg,  step_next;
    logic               out_valid_reg, out_valid_next;

    logic [BLK_W-1:0]   req_blk_reg;
    logic [BLK_W-1:0]   grant_reg;
    logic [ENTRY_W-1:0] cache_rd_reg;
    logic [ENTRY_W-1:0] link_rd_reg;
    logic               out_status_reg;
    logic [BLK_W-1:0]   out_block_reg;

    logic [STEP_W-1:0]  step_prev;
    logic [CIDX_W-1:0]  step_slot;
    logic [CIDX_W-1:0]  prev_slot;

    logic               cache_we;
    logic [CIDX_W-1:0]  cache_waddr;
    logic [ENTRY_W-1:0] cache_wdata;
    logic               cache_re;
    logic [CIDX_W-1:0]  cache_raddr;
    logic               link_we;
    logic [LINK_AW-1:0] link_waddr;
    logic [ENTRY_W-1:0] link_wdata;
    logic               link_re;
    logic [LINK_AW-1:0] link_raddr;

    assign step_prev = step_reg - STEP_W'(1);
    assign step_slot = step_reg[CIDX_W-1:0];
    assign prev_slot = step_prev[CIDX_W-1:0];

    // status toward the controller
    assign stat.blk_in_range = CMP_W'(blk_in) < CMP_W'(DISK_BLOCKS);
    assign stat.count_zero   = (count_reg == '0);
    assign stat.count_full   = (count_reg == LAST_SLOT);
    assign stat.head_end     = (head_reg == END_MARK) ||
                               (CMP_W'(head_reg) >= CMP_W'(DISK_BLOCKS));
    assign stat.spill_last   = (step_reg == STEP_W'(CACHE_ENTRIES - 1));
    assign stat.refill_last  = (step_reg == STEP_W'(CACHE_ENTRIES));
    assign stat.out_free     = !out_valid_reg || res_ready;

    // cache port: one write, one registered read
    always_comb
    begin
        cache_we    = 1'b0;
        cache_waddr = count_reg;
        cache_wdata = {1'b0, blk_in};
        if (cmd.push)
        begin
            cache_we = 1'b1;
        end
        else if (cmd.refill_step && !stat.refill_last)
        begin
            cache_we    = 1'b1;
            cache_waddr = prev_slot;
            cache_wdata = link_rd_reg;
        end

        cache_re    = cmd.pop || cmd.spill_start || cmd.spill_step;
        cache_raddr = step_slot;
        if (cmd.pop)
        begin
            cache_raddr = count_reg - CIDX_W'(1);
        end
        else if (cmd.spill_start)
        begin
            cache_raddr = '0;
        end
    end

    // link memory port: node of block b sits at {b, slot}
    always_comb
    begin
        link_we    = cmd.spill_start || cmd.spill_step;
        link_waddr = {req_blk_reg[NODE_W-1:0], prev_slot};
        link_wdata = cache_rd_reg;
        if (cmd.spill_start)
        begin
            link_waddr = {blk_in[NODE_W-1:0], LAST_SLOT};
            link_wdata = head_reg;
        end

        link_re    = cmd.refill_start || cmd.refill_step;
        link_raddr = {grant_reg[NODE_W-1:0], step_slot};
        if (cmd.refill_start)
        begin
            link_raddr = {head_reg[NODE_W-1:0], CIDX_W'(0)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cache_we)
        begin
            cache_mem[cache_waddr] <= cache_wdata;
        end
        if (cache_re)
        begin
            cache_rd_reg <= cache_mem[cache_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    // control state next values
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        step_next  = step_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CIDX_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CIDX_W'(1);
        end
        else if (cmd.spill_step && stat.spill_last)
        begin
            count_next = '0;
            head_next  = {1'b0, req_blk_reg};
        end
        else if (cmd.refill_step && stat.refill_last)
        begin
            count_next = LAST_SLOT;
            head_next  = link_rd_reg;
        end

        if (cmd.spill_start || cmd.refill_start)
        begin
            step_next = STEP_W'(1);
        end
        else if (cmd.spill_step || cmd.refill_step)
        begin
            step_next = step_reg + STEP_W'(1);
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= END_MARK;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_blk_reg <= blk_in;
        end
        if (cmd.refill_start)
        begin
            grant_reg <= head_reg[BLK_W-1:0];
        end
        if (cmd.load_out)
        begin
            unique case (cmd.res_sel)
                RES_ZERO:
                begin
                    out_status_reg <= STATUS_OK;
                    out_block_reg  <= '0;
                end
                RES_NOSPACE:
                begin
                    out_status_reg <= STATUS_NOSPACE;
                    out_block_reg  <= '0;
                end
                RES_CACHE:
                begin
                    out_status_reg <= STATUS_OK;
                    out_block_reg  <= cache_rd_reg[BLK_W-1:0];
                end
                RES_HEAD:
                begin
                    out_status_reg <= STATUS_OK;
                    out_block_reg  <= grant_reg;
                end
                default:
                begin
                    out_status_reg <= STATUS_OK;
                    out_block_reg  <= '0;
                end
            endcase
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_block  = out_block_reg;

endmodule

`default_nettype wire

// File: rtl/cfba_ctrl.sv
// ----------------------------------------------------------------------------
// cfba_ctrl: allocator controller
// Takes one request at a time, picks push, pop, spill, refill or no action,
// sequences their sweeps and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_ctrl
    import cfba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_kind,
    output logic            in_ready,
    input  wire cfba_stat_t stat,
    output cfba_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPILL,
        ST_REFILL,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    cfba_res_sel_t res_sel_reg, res_sel_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;

        cmd              = '0;
        cmd.res_sel      = res_sel_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    if (in_kind == KIND_FREE)
                    begin
                        res_sel_next = RES_ZERO;
                        if (!stat.blk_in_range)
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (stat.count_full)
                        begin
                            cmd.spill_start = 1'b1;
                            state_next      = ST_SPILL;
                        end
                        else
                        begin
                            cmd.push   = 1'b1;
                            state_next = ST_FINISH;
                        end
                    end
                    else if (stat.count_zero)
                    begin
                        if (stat.head_end)
                        begin
                            res_sel_next = RES_NOSPACE;
                            state_next   = ST_FINISH;
                        end
                        else
                        begin
                            cmd.refill_start = 1'b1;
                            state_next       = ST_REFILL;
                        end
                    end
                    else
                    begin
                        cmd.pop      = 1'b1;
                        res_sel_next = RES_CACHE;
                        state_next   = ST_FINISH;
                    end
                end
            end
            ST_SPILL:
            begin
                cmd.spill_step = 1'b1;
                if (stat.spill_last)
                begin
                    res_sel_next = RES_ZERO;
                    state_next   = ST_FINISH;
                end
            end
            ST_REFILL:
            begin
                cmd.refill_step = 1'b1;
                if (stat.refill_last)
                begin
                    res_sel_next = RES_HEAD;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            res_sel_reg <= RES_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/chained_free_block_allocator.sv
// ----------------------------------------------------------------------------
// chained_free_block_allocator: chained free block list allocator
// Grants and takes back disk block numbers through a cache of free blocks
// that spills into, and refills from, link nodes kept in the freed blocks.
// ----------------------------------------------------------------------------
//  channel  dir  payload                        transaction
//  req      in   kind, block_number             allocate or free one block
//  res      out  status, allocated_block        one result per request
//
//  A push or pop acts on acceptance; the finish state then loads the result
//  into the output register. A free into a full cache runs the spill sweep
//  and an allocate from an empty cache the refill sweep, one cache word per
//  cycle through one link memory port. One request is in work at a time.
//  Reset empties the pool at once; there is no clearing pass. A stalled
//  result holds the controller in its finish state until res takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_free_block_allocator
    import cfba_pkg::*;
#(
    parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int unsigned DISK_BLOCKS   = DISK_BLOCKS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfba_req_if.sink   req,
    cfba_res_if.source res
);

    cfba_cmd_t  cmd;
    cfba_stat_t stat;

    cfba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_kind  (req.kind),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cfba_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .DISK_BLOCKS   (DISK_BLOCKS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_in     (req.block_number),
        .cmd        (cmd),
        .stat       (stat),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .res_status (res.status),
        .res_block  (res.allocated_block)
    );

endmodule

`default_nettype wire

// File: test/chained_free_block_allocator_test.sv
// ----------------------------------------------------------------------------
// chained_free_block_allocator_test: free block list allocator testbench
// Drives allocate and free transactions with random gaps and result stalls.
// Expected grants come from a behavioral copy of the free cache and link
// chain, or for typed rows from the short directed table, which runs first.
// Then come random bursts of frees and allocations, which spill the cache
// into link blocks, refill it from the chain and drain the pool dry.
// ----------------------------------------------------------------------------
module chained_free_block_allocator_test;
    import cfba_pkg::*;

    localparam int CACHE_N   = CACHE_ENTRIES_DEF;
    localparam int DISK_N    = DISK_BLOCKS_DEF;
    localparam int RANDOM_N  = 500;
    localparam int HOLD_AT   = 120;
    localparam int HOLD_LEN  = 300;
    localparam int DRAIN_CYC = 2 * CACHE_N + 8;

    typedef struct packed {
        logic             kind;
        logic [BLK_W-1:0] block_number;
    } alloc_req_t;

    typedef struct packed {
        logic             status;
        logic [BLK_W-1:0] allocated_block;
    } grant_t;

    typedef struct {
        logic             kind;
        logic [BLK_W-1:0] block_number;
        bit               typed;
        logic             want_status;
        logic [BLK_W-1:0] want_block;
    } directed_row_t;

    logic clk;
    logic rst_n;

    cfba_req_if req_ch();
    cfba_res_if res_ch();

    chained_free_block_allocator #(
        .CACHE_ENTRIES (CACHE_N),
        .DISK_BLOCKS   (DISK_N)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // behavioral copy of the allocator state
    logic [ENTRY_W-1:0] cache_blocks [CACHE_N];
    int                 cache_fill;
    logic [ENTRY_W-1:0] chain_nodes [DISK_N*CACHE_N];

    grant_t           pending_grants [$];
    int               mismatches;
    int               sent;
    int               taken;
    int               alloc_cnt;
    int               free_cnt;
    int               nospace_cnt;
    int               spill_cnt;
    int               refill_cnt;
    bit               tx_calm;
    bit               rx_calm;
    logic [BLK_W-1:0] last_freed;

    directed_row_t directed_rows [21] = '{
        '{KIND_ALLOC, 10'h3FF, 1'b1, STATUS_NOSPACE, 10'h000},
        '{KIND_ALLOC, 10'h000, 1'b1, STATUS_NOSPACE, 10'h000},
        '{KIND_FREE,  10'h000, 1'b1, STATUS_OK,      10'h000},
        '{KIND_FREE,  10'h3FF, 1'b1, STATUS_OK,      10'h000},
        '{KIND_ALLOC, 10'h000, 1'b1, STATUS_OK,      10'h3FF},
        '{KIND_ALLOC, 10'h000, 1'b1, STATUS_OK,      10'h000},
        '{KIND_ALLOC, 10'h000, 1'b1, STATUS_NOSPACE, 10'h000},
        '{KIND_FREE,  10'h155, 1'b1, STATUS_OK,      10'h000},
        '{KIND_FREE,  10'h2AA, 1'b1, STATUS_OK,      10'h000},
        // double free goes unnoticed: the block is pushed twice
        '{KIND_FREE,  10'h2AA, 1'b1, STATUS_OK,      10'h000},
        '{KIND_ALLOC, 10'h155, 1'b1, STATUS_OK,      10'h2AA},
        '{KIND_ALLOC, 10'h000, 1'b1, STATUS_OK,      10'h2AA},
        '{KIND_ALLOC, 10'h000, 1'b1, STATUS_OK,      10'h155},
        '{KIND_ALLOC, 10'h000, 1'b1, STATUS_NOSPACE, 10'h000},
        '{KIND_FREE,  10'h200, 1'b0, STATUS_OK,      10'h000},
        '{KIND_FREE,  10'h001, 1'b0, STATUS_OK,      10'h000},
        '{KIND_ALLOC, 10'h3FF, 1'b0, STATUS_OK,      10'h000},
        '{KIND_FREE,  10'h3FE, 1'b0, STATUS_OK,      10'h000},
        '{KIND_ALLOC, 10'h000, 1'b0, STATUS_OK,      10'h000},
        '{KIND_ALLOC, 10'h000, 1'b0, STATUS_OK,      10'h000},
        '{KIND_ALLOC, 10'h000, 1'b0, STATUS_OK,      10'h000}
    };

    always #5 clk = ~clk;

    function automatic grant_t predict_grant(input alloc_req_t r);
        grant_t             g;
        logic [ENTRY_W-1:0] head;
        g.status = STATUS_OK;
        g.allocated_block = '0;
        head = cache_blocks[CACHE_N-1];
        if (r.kind == KIND_FREE)
        begin
            if (int'(r.block_number) >= DISK_N)
            begin
                // out-of-range free: ignored
            end
            else if (cache_fill >= CACHE_N - 1)
            begin
                // spill the whole cache into the freed block, which becomes the head
                for (int i = 0; i < CACHE_N; i++)
                    chain_nodes[int'(r.block_number) * CACHE_N + i] = cache_blocks[i];
                cache_fill = 0;
                cache_blocks[CACHE_N-1] = {1'b0, r.block_number};
                spill_cnt++;
            end
            else
            begin
                cache_blocks[cache_fill] = {1'b0, r.block_number};
                cache_fill++;
            end
        end
        else if (cache_fill == 0)
        begin
            if (head == END_MARK || int'(head) >= DISK_N)
            begin
                g.status = STATUS_NOSPACE;
                nospace_cnt++;
            end
            else
            begin
                // refill from the head node and grant the head block itself
                for (int i = 0; i < CACHE_N; i++)
                    cache_blocks[i] = chain_nodes[int'(head) * CACHE_N + i];
                cache_fill = CACHE_N - 1;
                g.allocated_block = head[BLK_W-1:0];
                refill_cnt++;
            end
        end
        else
        begin
            cache_fill--;
            g.allocated_block = cache_blocks[cache_fill][BLK_W-1:0];
        end
        return g;
    endfunction

    function automatic logic [BLK_W-1:0] pick_block();
        logic [BLK_W-1:0] b;
        case ($urandom_range(0, 9))
            0:       b = '0;
            1:       b = '1;
            2, 3:    b = last_freed;
            default: b = BLK_W'($urandom_range(0, DISK_N - 1));
        endcase
        return b;
    endfunction

    task automatic send_request(input logic kind, input logic [BLK_W-1:0] blk,
                                input bit typed, input grant_t want);
        int     gap;
        grant_t predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.block_number <= blk;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        predicted = predict_grant(alloc_req_t'{kind, blk});
        pending_grants.push_back(typed ? want : predicted);
        sent++;
        if (kind == KIND_FREE)
        begin
            free_cnt++;
            last_freed = blk;
        end
        else
            alloc_cnt++;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
    endtask

    // mostly one kind per burst, with a stray request of the other kind mixed in
    task automatic run_burst(input bit freeing, input int len);
        logic kind;
        for (int n = 0; n < len; n++)
        begin
            kind = freeing ? KIND_FREE : KIND_ALLOC;
            if ($urandom_range(0, 7) == 0)
                kind = !kind;
            send_request(kind, BLK_W'($urandom_range(0, DISK_N - 1)) & pick_block()
                         | pick_block(), 1'b0, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= KIND_ALLOC;
        req_ch.block_number <= '0;
        res_ch.ready        <= 1'b0;
        mismatches = 0;
        sent = 0;
        taken = 0;
        alloc_cnt = 0;
        free_cnt = 0;
        nospace_cnt = 0;
        spill_cnt = 0;
        refill_cnt = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        last_freed = '0;
        cache_fill = 0;
        for (int i = 0; i < CACHE_N; i++)
            cache_blocks[i] = '0;
        cache_blocks[CACHE_N-1] = END_MARK;
        for (int i = 0; i < DISK_N * CACHE_N; i++)
            chain_nodes[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].kind, directed_rows[r].block_number,
                         directed_rows[r].typed,
                         grant_t'{directed_rows[r].want_status, directed_rows[r].want_block});

        // spill into the chain, then drain back through it toward no-space
        run_burst(1'b1, 70);
        run_burst(1'b0, 80);
        while (sent < RANDOM_N)
            run_burst($urandom_range(0, 9) < 6, $urandom_range(1, 70));
        req_ch.valid <= 1'b0;

        while (pending_grants.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("covered %0d requests: %0d allocations, %0d frees, %0d no-space results",
                 sent, alloc_cnt, free_cnt, nospace_cnt);
        $display("chain activity: %0d spills into link blocks, %0d refills from the chain",
                 spill_cnt, refill_cnt);
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin : result_sink
        int     gap;
        bit     hold_done;
        grant_t got;
        grant_t want;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_calm ? 0 : $urandom_range(0, 8);
            if (!hold_done && taken >= HOLD_AT)
            begin
                gap = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            got = grant_t'{res_ch.status, res_ch.allocated_block};
            taken++;
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result status %0d block %0d", $time,
                         got.status, got.allocated_block);
                mismatches++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d", $time,
                             want.status, got.status);
                    mismatches++;
                end
                if (got.allocated_block !== want.allocated_block)
                begin
                    $display("%0t: allocated_block mismatch, expected %0d actual %0d",
                             $time, want.allocated_block, got.allocated_block);
                    mismatches++;
                end
            end
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
